// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition in a cycle implies another in the same cycle.
`define DTI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition in a cycle implies another in the next cycle.
`define DTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dti_pkg.sv =====
`timescale 1ns / 1ps

package dti_pkg;

    localparam logic [1:0] ACT_NODE     = 2'd0;
    localparam logic [1:0] ACT_FEATURE  = 2'd1;
    localparam logic [1:0] ACT_CLASSIFY = 2'd2;

    localparam logic [7:0] DEPTH_LIMIT_RESET = 8'd16;
    localparam logic       REG_DEPTH_LIMIT   = 1'b0;

    typedef struct packed {
        logic               leaf;
        logic [3:0]         feature;
        logic signed [31:0] threshold;
        logic [7:0]         left;
        logic [7:0]         right;
        logic [7:0]         label;
    } node_t;

    typedef struct packed {
        logic [7:0] label;
        logic       err;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NODE,
        ST_EVAL,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

// ===== src/dti_node_mem.sv =====
`timescale 1ns / 1ps

module dti_node_mem
    import dti_pkg::*;
#(
    parameter int NODE_COUNT = 256,
    parameter int IDX_W      = 8
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  node_t            wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output node_t            rd_data
);

    node_t mem [NODE_COUNT];
    node_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/dti_feat_mem.sv =====
`timescale 1ns / 1ps

module dti_feat_mem
#(
    parameter int FEATURE_COUNT = 16,
    parameter int IDX_W         = 4
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic signed [31:0] wr_data,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic signed [31:0] rd_data
);

    logic signed [31:0] mem [FEATURE_COUNT];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/dti_walker.sv =====
`timescale 1ns / 1ps

module dti_walker
    import dti_pkg::*;
#(
    parameter int NODE_COUNT    = 256,
    parameter int FEATURE_COUNT = 16,
    parameter int NIDX_W        = 8,
    parameter int FIDX_W        = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [7:0]        depth_limit,
    output logic              busy,
    output logic [NIDX_W-1:0] node_rd_addr,
    input  node_t             node_rd_data,
    output logic [FIDX_W-1:0] feat_rd_addr,
    input  logic signed [31:0] feat_rd_data,
    output logic              out_valid,
    input  logic              out_stall,
    output result_t           out_word
);

    state_t            state_reg, state_next;
    logic [NIDX_W-1:0] cur_reg, cur_next;
    logic [7:0]        visits_reg, visits_next;
    result_t           res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_word_reg, out_word_next;

    logic [31:0]        feat_wide;
    logic [31:0]        child_wide;
    logic               feat_oob;
    logic signed [31:0] feat_val;
    logic [7:0]         child;

    assign feat_wide    = 32'(node_rd_data.feature);
    assign feat_rd_addr = feat_wide[FIDX_W-1:0];
    assign feat_oob     = feat_wide >= FEATURE_COUNT;
    assign feat_val     = feat_oob ? 32'sd0 : feat_rd_data;
    assign child        = (feat_val <= $signed(node_rd_data.threshold)) ? node_rd_data.left
                                                                        : node_rd_data.right;
    assign child_wide   = 32'(child);
    assign node_rd_addr = cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        visits_reg   <= visits_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        visits_next    = visits_reg;
        res_next       = res_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cur_next    = '0;
                    visits_next = 8'd0;
                    state_next  = ST_NODE;
                end
            end
            ST_NODE:
            begin
                if (visits_reg >= depth_limit)
                begin
                    res_next   = '{label: 8'd0, err: 1'b1};
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                visits_next = 8'(visits_reg + 8'd1);
                if (node_rd_data.leaf)
                begin
                    res_next   = '{label: node_rd_data.label, err: 1'b0};
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (child_wide >= NODE_COUNT)
                begin
                    res_next   = '{label: 8'd0, err: 1'b1};
                    state_next = ST_DONE;
                end
                else
                begin
                    cur_next   = child_wide[NIDX_W-1:0];
                    state_next = ST_NODE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_word_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== src/decision_tree_inference_unit.sv =====
`timescale 1ns / 1ps

// Decision tree classifier. Input words arrive on in_valid / in_stall with the
// action field choosing a node write, a feature write or a classification.
// A node or feature write gives no output word.
// A classification walks the tree from node 0. An inner node takes a node
// table read, a feature store read and a threshold compare, and a leaf
// the node table read alone; the walk ends at a leaf, or when the visit
// count reaches the depth limit, which sets depth_error.
// The input side stalls for the whole walk and is free again in the cycle
// the result word appears.
// The result word (leaf_label, depth_error) sits in an output register.
// While the receiver holds out_stall, the word stays put and further writes
// are still taken; a second classification waits before loading its result.
// The depth_limit register sits on the APB port at address 0.
// Reset empties the output register, returns the walker to idle and sets
// depth_limit to 16; the node table and feature store are not cleared.

module decision_tree_inference_unit
    import dti_pkg::*;
#(
    parameter int NODE_COUNT    = 256,
    parameter int FEATURE_COUNT = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [7:0]         node_slot,
    input  logic               node_leaf,
    input  logic [3:0]         node_feature,
    input  logic signed [31:0] node_threshold,
    input  logic [7:0]         node_left,
    input  logic [7:0]         node_right,
    input  logic [7:0]         node_label,
    input  logic [3:0]         feature_slot,
    input  logic signed [31:0] feature_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         leaf_label,
    output logic               depth_error
);

    localparam int NIDX_W = $clog2(NODE_COUNT);
    localparam int FIDX_W = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

    logic [7:0] depth_limit_reg, depth_limit_next;

    logic              accept;
    logic              busy;
    logic [31:0]       node_slot_wide;
    logic [31:0]       feat_slot_wide;
    logic              node_wr_en;
    logic              feat_wr_en;
    node_t             node_wr_data;
    logic [NIDX_W-1:0] node_rd_addr;
    node_t             node_rd_data;
    logic [FIDX_W-1:0] feat_rd_addr;
    logic signed [31:0] feat_rd_data;
    result_t           out_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg <= DEPTH_LIMIT_RESET;
        end
        else
        begin
            depth_limit_reg <= depth_limit_next;
        end
    end

    always_comb
    begin
        depth_limit_next = depth_limit_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_DEPTH_LIMIT))
        begin
            depth_limit_next = pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEPTH_LIMIT) ? {24'd0, depth_limit_reg} : 32'd0;

    assign in_stall       = busy;
    assign accept         = in_valid && !in_stall;
    assign node_slot_wide = 32'(node_slot);
    assign feat_slot_wide = 32'(feature_slot);
    assign node_wr_en     = accept && (action == ACT_NODE) && (node_slot_wide < NODE_COUNT);
    assign feat_wr_en     = accept && (action == ACT_FEATURE)
                            && (feat_slot_wide < FEATURE_COUNT);

    assign node_wr_data = '{leaf:      node_leaf,
                            feature:   node_feature,
                            threshold: node_threshold,
                            left:      node_left,
                            right:     node_right,
                            label:     node_label};

    dti_node_mem #(
        .NODE_COUNT (NODE_COUNT),
        .IDX_W      (NIDX_W)
    ) u_node_mem (
        .clk     (clk),
        .wr_en   (node_wr_en),
        .wr_addr (node_slot_wide[NIDX_W-1:0]),
        .wr_data (node_wr_data),
        .rd_addr (node_rd_addr),
        .rd_data (node_rd_data)
    );

    dti_feat_mem #(
        .FEATURE_COUNT (FEATURE_COUNT),
        .IDX_W         (FIDX_W)
    ) u_feat_mem (
        .clk     (clk),
        .wr_en   (feat_wr_en),
        .wr_addr (feat_slot_wide[FIDX_W-1:0]),
        .wr_data (feature_value),
        .rd_addr (feat_rd_addr),
        .rd_data (feat_rd_data)
    );

    dti_walker #(
        .NODE_COUNT    (NODE_COUNT),
        .FEATURE_COUNT (FEATURE_COUNT),
        .NIDX_W        (NIDX_W),
        .FIDX_W        (FIDX_W)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept && (action == ACT_CLASSIFY)),
        .depth_limit  (depth_limit_reg),
        .busy         (busy),
        .node_rd_addr (node_rd_addr),
        .node_rd_data (node_rd_data),
        .feat_rd_addr (feat_rd_addr),
        .feat_rd_data (feat_rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_word     (out_word)
    );

    assign leaf_label  = out_word.label;
    assign depth_error = out_word.err;

endmodule

// ===== src/dti_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dti_checker
    import dti_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] action,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] leaf_label,
    input logic       depth_error
);

    logic [8:0] word_seen;

    assign word_seen = {leaf_label, depth_error};

    `DTI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")
    `DTI_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(word_seen), "stalled word changed")
    `DTI_ASSERT_SAME(a_err_label, out_valid && depth_error, leaf_label == 8'd0, "flagged label nonzero")
    `DTI_ASSERT_NEXT(a_walk_busy, in_valid && !in_stall && (action == ACT_CLASSIFY), in_stall, "walk not stalling")

endmodule

bind decision_tree_inference_unit dti_checker u_dti_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import dti_pkg::*;

    localparam logic [1:0] ACT_NONE         = 2'd3;
    localparam logic [2:0] ADDR_DEPTH_LIMIT = {REG_DEPTH_LIMIT, 2'b00};

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  node_slot;
        logic        node_leaf;
        logic [3:0]  node_feature;
        logic [31:0] node_threshold;
        logic [7:0]  node_left;
        logic [7:0]  node_right;
        logic [7:0]  node_label;
        logic [3:0]  feature_slot;
        logic [31:0] feature_value;
    } tree_word_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic [7:0]         node_slot;
    logic               node_leaf;
    logic [3:0]         node_feature;
    logic signed [31:0] node_threshold;
    logic [7:0]         node_left;
    logic [7:0]         node_right;
    logic [7:0]         node_label;
    logic [3:0]         feature_slot;
    logic signed [31:0] feature_value;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         leaf_label;
    logic               depth_error;

    // Tree and feature contents as the block should hold them.
    node_t              tree_nodes [0:255];
    logic signed [31:0] feature_vals [0:15];
    logic [7:0]         depth_limit_now = DEPTH_LIMIT_RESET;
    result_t            predicted [$];
    result_t            foreseen;
    result_t            oldest;

    // Words waiting to go out, and which entries they will have written.
    tree_word_t         outbound_words [$];
    tree_word_t         live_word;
    bit                 node_known [0:255];
    int                 node_pool [$];
    bit                 feat_known [0:15];
    int                 feat_pool [$];

    int                 send_gap;
    bit                 send_calm;
    int                 recv_gap;
    bit                 recv_calm;
    int                 mismatches;
    int                 words_sent;
    int                 classify_count;
    int                 flagged_count;
    int                 config_count;

    logic [7:0]         corner_limits [4] = '{8'd2, 8'd1, 8'd0, 8'd255};
    logic [7:0]         phase_limits [6] = '{8'd255, 8'd1, 8'd5, 8'd16, 8'd2, 8'd16};

    decision_tree_inference_unit dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic result_t walk_tree();
        result_t    res;
        logic [7:0] cur;
        int         visits;
        node_t      n;
        res.label = '0;
        res.err = 1'b1;
        cur = '0;
        visits = 0;
        while (visits < depth_limit_now)
        begin
            n = tree_nodes[cur];
            visits++;
            if (n.leaf)
            begin
                res.label = n.label;
                res.err = 1'b0;
                break;
            end
            if ($signed(feature_vals[n.feature]) <= $signed(n.threshold))
                cur = n.left;
            else
                cur = n.right;
        end
        return res;
    endfunction

    function automatic void note_node(logic [7:0] slot);
        if (!node_known[slot])
        begin
            node_known[slot] = 1'b1;
            node_pool.push_back(int'(slot));
        end
    endfunction

    function automatic logic [7:0] pick_node();
        return 8'(node_pool[$urandom_range(0, node_pool.size() - 1)]);
    endfunction

    function automatic logic [3:0] pick_feature();
        return 4'(feat_pool[$urandom_range(0, feat_pool.size() - 1)]);
    endfunction

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return ($urandom_range(0, 4) - 32'd2) << 16;
            4: return (($urandom_range(0, 4) - 32'd2) << 16) + $urandom_range(0, 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic tree_word_t random_word(logic [1:0] act);
        tree_word_t   w;
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        w = noise[$bits(tree_word_t)-1:0];
        w.action = act;
        return w;
    endfunction

    function automatic void push_node(logic [7:0] slot, logic leaf, logic [3:0] feat,
                                      logic [31:0] thr, logic [7:0] lft, logic [7:0] rgt,
                                      logic [7:0] lbl);
        tree_word_t w;
        w = random_word(ACT_NODE);
        w.node_slot = slot;
        w.node_leaf = leaf;
        w.node_feature = feat;
        w.node_threshold = thr;
        w.node_left = lft;
        w.node_right = rgt;
        w.node_label = lbl;
        outbound_words.push_back(w);
        note_node(slot);
    endfunction

    function automatic void push_feature(logic [3:0] slot, logic [31:0] val);
        tree_word_t w;
        w = random_word(ACT_FEATURE);
        w.feature_slot = slot;
        w.feature_value = val;
        outbound_words.push_back(w);
        if (!feat_known[slot])
        begin
            feat_known[slot] = 1'b1;
            feat_pool.push_back(int'(slot));
        end
    endfunction

    function automatic void push_classify();
        outbound_words.push_back(random_word(ACT_CLASSIFY));
    endfunction

    function automatic void push_random_leaf(logic [7:0] slot);
        push_node(slot, 1'b1, 4'($urandom), $urandom, 8'($urandom), 8'($urandom),
                  8'($urandom));
    endfunction

    // Built from the leaf upward so that every child already holds a node;
    // the top of the chain lands in slot 0 where every walk starts.
    function automatic void grow_chain(int len, bit straight);
        logic [7:0] below;
        logic [7:0] slot;
        logic [7:0] other;
        slot = (len == 1) ? 8'd0 : 8'($urandom_range(1, 255));
        push_random_leaf(slot);
        below = slot;
        for (int i = 1; i < len; i++)
        begin
            slot = (i == len - 1) ? 8'd0 : 8'($urandom_range(1, 255));
            note_node(slot);
            other = straight ? below : pick_node();
            if ($urandom_range(0, 1) == 0)
                push_node(slot, 1'b0, pick_feature(), pick_q16(), below, other, 8'($urandom));
            else
                push_node(slot, 1'b0, pick_feature(), pick_q16(), other, below, 8'($urandom));
            below = slot;
        end
    endfunction

    function automatic void fill_phase(int count, logic [7:0] limit);
        int         made;
        int         pick;
        int         len;
        logic [7:0] slot;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
                if (limit > 0 && limit <= 40 && $urandom_range(0, 2) == 0)
                    len = int'(limit) - 1 + int'($urandom_range(0, 2));
                if (len < 1)
                    len = 1;
                grow_chain(len, 1'($urandom_range(0, 1)));
                made += len;
                repeat ($urandom_range(0, 3))
                begin
                    push_feature(4'($urandom_range(0, 15)), pick_q16());
                    made++;
                end
                repeat ($urandom_range(1, 4))
                begin
                    push_classify();
                    made++;
                end
            end
            else if (pick < 7)
            begin
                slot = 8'($urandom_range(0, 255));
                note_node(slot);
                if ($urandom_range(0, 2) == 0)
                    push_random_leaf(slot);
                else
                    push_node(slot, 1'b0, pick_feature(), pick_q16(), pick_node(), pick_node(),
                              8'($urandom));
                made++;
            end
            else if (pick < 8)
            begin
                push_feature(4'($urandom_range(0, 15)), pick_q16());
                made++;
            end
            else if (pick < 9)
            begin
                push_classify();
                made++;
            end
            else
            begin
                outbound_words.push_back(random_word(ACT_NONE));
                made++;
            end
        end
    endfunction

    task automatic wait_idle(int settle);
        @(negedge clk);
        while (outbound_words.size() != 0 || in_valid || predicted.size() != 0)
            @(negedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_depth_limit(logic [7:0] limit);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_DEPTH_LIMIT;
        pwdata <= {24'($urandom), limit};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        depth_limit_now = limit;
        config_count++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[7:0] !== limit)
        begin
            $error("depth_limit readback expected %0d, got %0d", limit, prdata[7:0]);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = $urandom_range(0, 4);
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                words_sent++;
                case (live_word.action)
                    ACT_NODE:
                        tree_nodes[live_word.node_slot] = {live_word.node_leaf,
                            live_word.node_feature, live_word.node_threshold,
                            live_word.node_left, live_word.node_right, live_word.node_label};
                    ACT_FEATURE:
                        feature_vals[live_word.feature_slot] = live_word.feature_value;
                    ACT_CLASSIFY:
                    begin
                        foreseen = walk_tree();
                        predicted.push_back(foreseen);
                        classify_count++;
                        if (foreseen.err)
                            flagged_count++;
                    end
                    default:
                        ;
                endcase
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (outbound_words.size() > 0)
                begin
                    live_word = outbound_words.pop_front();
                    action <= live_word.action;
                    node_slot <= live_word.node_slot;
                    node_leaf <= live_word.node_leaf;
                    node_feature <= live_word.node_feature;
                    node_threshold <= live_word.node_threshold;
                    node_left <= live_word.node_left;
                    node_right <= live_word.node_right;
                    node_label <= live_word.node_label;
                    feature_slot <= live_word.feature_slot;
                    feature_value <= live_word.feature_value;
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_calm = !send_calm;
                    send_gap = send_calm ? 0 : $urandom_range(0, 4);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = $urandom_range(0, 4);
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted.size() == 0)
                begin
                    $error("result word with no classification pending: leaf_label %0d, depth_error %0d",
                           leaf_label, depth_error);
                    mismatches++;
                end
                else
                begin
                    oldest = predicted.pop_front();
                    if (leaf_label !== oldest.label)
                    begin
                        $error("leaf_label expected %0d, got %0d", oldest.label, leaf_label);
                        mismatches++;
                    end
                    if (depth_error !== oldest.err)
                    begin
                        $error("depth_error expected %0d, got %0d", oldest.err, depth_error);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                recv_gap = recv_calm ? 0 : $urandom_range(0, 4);
            end
            else if (out_valid && out_stall && recv_gap > 0)
                recv_gap--;
            out_stall <= (recv_gap > 0);
        end
    end

    initial
    begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        out_stall <= 1'b0;
        action <= ACT_NONE;
        node_slot <= '0;
        node_leaf <= 1'b0;
        node_feature <= '0;
        node_threshold <= '0;
        node_left <= '0;
        node_right <= '0;
        node_label <= '0;
        feature_slot <= '0;
        feature_value <= '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        push_feature(4'd0, 32'h8000_0000);
        push_feature(4'd15, 32'h7fff_ffff);
        push_feature(4'd1, 32'h0000_0000);
        push_node(8'd0, 1'b1, 4'hf, 32'hffff_ffff, 8'hff, 8'hff, 8'hff);
        push_classify();
        push_node(8'd255, 1'b1, 4'h0, 32'h0, 8'h00, 8'h00, 8'h00);
        push_node(8'd0, 1'b0, 4'hf, 32'h7fff_ffff, 8'd255, 8'd0, 8'haa);
        push_classify();
        push_node(8'd0, 1'b0, 4'h0, 32'h8000_0000, 8'd0, 8'd255, 8'h55);
        push_classify();
        push_feature(4'd0, 32'h8000_0001);
        push_classify();
        outbound_words.push_back(random_word(ACT_NONE));

        wait_idle(20);
        set_depth_limit(8'd3);
        @(negedge clk);
        push_node(8'd7, 1'b1, 4'h0, 32'h0, 8'h00, 8'h00, 8'h5a);
        push_node(8'd9, 1'b0, 4'h1, 32'h0, 8'd7, 8'd7, 8'h00);
        push_node(8'd0, 1'b0, 4'h1, 32'h0, 8'd9, 8'd9, 8'h00);
        push_classify();
        foreach (corner_limits[i])
        begin
            wait_idle(20);
            set_depth_limit(corner_limits[i]);
            @(negedge clk);
            push_classify();
        end

        for (int p = 0; p < 6; p++)
        begin
            wait_idle(20);
            set_depth_limit(p == 3 ? 8'($urandom_range(1, 255)) : phase_limits[p]);
            @(negedge clk);
            fill_phase(150, depth_limit_now);
        end
        wait_idle(800);

        $display("Sent %0d input words; %0d classifications checked, %0d hit the depth guard,",
                 words_sent, classify_count, flagged_count);
        $display("under %0d depth_limit settings including 0, 1 and 255.", config_count);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
